[rtl/sign_assignment_sum_solver_unit_assert.svh]
`ifndef SIGN_ASSIGNMENT_SUM_SOLVER_UNIT_ASSERT_SVH
`define SIGN_ASSIGNMENT_SUM_SOLVER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SASS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sass_pkg.sv]
package sass_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam int unsigned SUM_SPAN_DEF  = 32768;

  localparam int unsigned VAL_W   = 8;
  localparam int unsigned TGT_W   = 15;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned DIFF_W  = 9;
  localparam int unsigned WORD_W  = 256;
  localparam int unsigned WORD_LW = 8;

  typedef struct packed {
    logic                     en;
    logic                     bank;
    logic [CNT_W-1:0]         idx;
    logic signed [VAL_W-1:0]  data;
  } elem_wr_t;

  typedef struct packed {
    logic                     bank;
    logic [CNT_W-1:0]         n;
    logic signed [DIFF_W-1:0] diff;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

[rtl/sign_assignment_sum_solver_unit.sv]
// sign assignment solver for a target sum
// input channel (in_valid_i/in_ready_o): one signed element per beat, last_i closes
// a sequence; elements past MAX_ITEMS are dropped, the closing beat still solves.
// config channel (cfg_valid_i/cfg_ready_o): signed target, always ready; write it
// only while the block is idle. result channel (out_valid_o/out_ready_i): n-1 beats
// of position_o per sequence of n elements, last_res_o on the final one; a sequence
// of one element gives no beat.
// input takes one beat per cycle; two element banks let the next sequence load
// while the previous one is solved, and the input stalls only while both are busy.
// a solve clears and seeds reach row one, sweeps one row per further element
// through the single-read-port reach memory (W = SUM_SPAN/256 row words per row,
// 128 by default), traces back element by element with one more step per
// minus-signed element, and sends the result beats. results leave through an
// output register, so a stalled receiver holds the solver and nothing is lost.
// reset clears control state and the target; reach rows are rewritten per
// sequence, so no clearing pass runs after reset.
module sign_assignment_sum_solver_unit #(
  parameter int unsigned MAX_ITEMS = sass_pkg::MAX_ITEMS_DEF,
  parameter int unsigned SUM_SPAN  = sass_pkg::SUM_SPAN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sass_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic signed [sass_pkg::TGT_W-1:0] cfg_target_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sass_pkg::POS_W-1:0]        position_o,
  output logic                              last_res_o
);
  import sass_pkg::*;

  logic signed [TGT_W-1:0] target_q;
  elem_wr_t                elem_wr;
  job_t                    job_in, job_out;
  logic                    job_push, job_pop, job_empty;
  release_t                rel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_target_i;
    end
  end

  sass_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .elem_wr_o  (elem_wr),
    .job_push_o (job_push),
    .job_o      (job_in),
    .rel_i      (rel)
  );

  sass_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .pop_i       (job_pop),
    .empty_o     (job_empty),
    .pop_data_o  (job_out)
  );

  sass_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .SUM_SPAN  (SUM_SPAN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .target_i    (target_q),
    .elem_wr_i   (elem_wr),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .rel_o       (rel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .last_res_o  (last_res_o)
  );

endmodule

[rtl/sass_fifo.sv]
module sass_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sass_pkg::job_t  push_data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output sass_pkg::job_t  pop_data_o
);
  import sass_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rp_q];

endmodule

[rtl/sass_front.sv]
module sass_front #(
  parameter int unsigned MAX_ITEMS = sass_pkg::MAX_ITEMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [sass_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  output sass_pkg::elem_wr_t                elem_wr_o,
  output logic                              job_push_o,
  output sass_pkg::job_t                    job_o,
  input  sass_pkg::release_t                rel_i
);
  import sass_pkg::*;

  logic [CNT_W-1:0]        cnt_q, cnt_d, n_new;
  logic                    bank_q;
  logic [1:0]              busy_q, busy_d;
  logic signed [VAL_W-1:0] a0_q, a1_q, a1_eff;
  logic                    accept, room, closing;

  assign in_ready_o = !busy_q[bank_q];
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CNT_W'(MAX_ITEMS));
  assign n_new      = room ? cnt_q + CNT_W'(1) : cnt_q;
  assign a1_eff     = (cnt_q == CNT_W'(1)) ? value_i : a1_q;
  assign closing    = accept && last_i;
  assign job_push_o = closing && (n_new >= CNT_W'(2));

  assign elem_wr_o.en   = accept && room;
  assign elem_wr_o.bank = bank_q;
  assign elem_wr_o.idx  = cnt_q;
  assign elem_wr_o.data = value_i;

  assign job_o.bank = bank_q;
  assign job_o.n    = n_new;
  assign job_o.diff = DIFF_W'(a0_q) - DIFF_W'(a1_eff);

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (job_push_o) busy_d[bank_q] = 1'b1;
    cnt_d = cnt_q;
    if (accept) cnt_d = closing ? '0 : n_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      if (job_push_o) bank_q <= ~bank_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == CNT_W'(0)) a0_q <= value_i;
    if (accept && cnt_q == CNT_W'(1)) a1_q <= value_i;
  end

endmodule

[rtl/sass_back.sv]
module sass_back #(
  parameter int unsigned MAX_ITEMS = sass_pkg::MAX_ITEMS_DEF,
  parameter int unsigned SUM_SPAN  = sass_pkg::SUM_SPAN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [sass_pkg::TGT_W-1:0] target_i,
  input  sass_pkg::elem_wr_t                elem_wr_i,
  input  logic                              job_empty_i,
  input  sass_pkg::job_t                    job_i,
  output logic                              job_pop_o,
  output sass_pkg::release_t                rel_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sass_pkg::POS_W-1:0]        position_o,
  output logic                              last_res_o
);
  import sass_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_ITEMS);
  localparam int unsigned NWORDS = SUM_SPAN / WORD_W;
  localparam int unsigned WA_W   = $clog2(NWORDS);
  localparam int unsigned SP_W   = $clog2(SUM_SPAN);
  localparam int unsigned J_W    = ((SP_W > TGT_W) ? SP_W : TGT_W) + 2;
  localparam int unsigned RA_W   = IDX_W + WA_W;
  localparam int unsigned ST_W   = $clog2(NWORDS + 2);
  localparam int unsigned ZERO   = SUM_SPAN / 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_LDA  = 4'd2;
  localparam logic [3:0] S_LDA2 = 4'd3;
  localparam logic [3:0] S_PASS = 4'd4;
  localparam logic [3:0] S_TBE  = 4'd5;
  localparam logic [3:0] S_TBA  = 4'd6;
  localparam logic [3:0] S_TBP  = 4'd7;
  localparam logic [3:0] S_TBM  = 4'd8;
  localparam logic [3:0] S_TBD  = 4'd9;
  localparam logic [3:0] S_I1   = 4'd10;
  localparam logic [3:0] S_RUN  = 4'd11;
  localparam logic [3:0] S_FILL = 4'd12;

  // element store, two banks
  logic signed [VAL_W-1:0] elem_mem [2**(IDX_W+1)];
  logic signed [VAL_W-1:0] elem_rd_q;
  logic [IDX_W:0]          elem_ra;

  // reach bits, one row per element, WORD_W sums per word
  logic [WORD_W-1:0] reach_mem [2**RA_W];
  logic [WORD_W-1:0] rdata_q;
  logic [RA_W-1:0]   rra, rwa;
  logic              rwe;
  logic [WORD_W-1:0] rwd;

  logic [3:0]              state_q, state_d;
  logic [ST_W-1:0]         step_q, step_d, wstep;
  logic [IDX_W-1:0]        i_q, i_d, i_prev;
  logic signed [VAL_W-1:0] a_q, a_d;
  logic signed [J_W-1:0]   j_q, j_d, start_q, start_d, jp, jm;
  logic [CNT_W-1:0]        rc_q, rc_d, oc_q, oc_d, n_q, n_d;
  logic                    fp_q, fp_d, fm, fin_q, fin_d, bank_q, bank_d;
  logic [POS_W-1:0]        run_pos_q, run_pos_d, emit_pos;
  logic [WORD_W-1:0]       cur_q, cur_d, prv_q, prv_d, incoming, plus_w, minus_w;
  logic [3*WORD_W-1:0]     win, win_p, win_m;
  logic [9:0]              sh_p, sh_m;
  logic                    jp_in, jm_in, j_in, start_in, emit, out_load;
  logic                    ov_q;
  logic [POS_W-1:0]        opos_q;
  logic                    olast_q;

  always_ff @(posedge clk_i) begin
    if (elem_wr_i.en) elem_mem[{elem_wr_i.bank, elem_wr_i.idx[IDX_W-1:0]}] <= elem_wr_i.data;
    elem_rd_q <= elem_mem[elem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rwe) reach_mem[rwa] <= rwd;
    rdata_q <= reach_mem[rra];
  end

  assign i_prev   = i_q - IDX_W'(1);
  assign jp       = j_q + J_W'(a_q);
  assign jm       = j_q - J_W'(a_q);
  assign jp_in    = !jp[J_W-1] && (jp[J_W-2:SP_W] == '0);
  assign jm_in    = !jm[J_W-1] && (jm[J_W-2:SP_W] == '0);
  assign j_in     = !j_q[J_W-1] && (j_q[J_W-2:SP_W] == '0);
  assign start_in = !start_q[J_W-1] && (start_q[J_W-2:SP_W] == '0);
  assign fm       = jm_in && rdata_q[jm[WORD_LW-1:0]];
  assign wstep    = step_q - ST_W'(2);

  // row update: shift the three-word window by +a and -a
  assign incoming = (step_q <= ST_W'(NWORDS)) ? rdata_q : '0;
  assign win      = {incoming, cur_q, prv_q};
  assign sh_p     = 10'(WORD_W) + 10'(a_q);
  assign sh_m     = 10'(WORD_W) - 10'(a_q);
  assign win_p    = win >> sh_p;
  assign win_m    = win >> sh_m;
  assign plus_w   = win_p[WORD_W-1:0];
  assign minus_w  = win_m[WORD_W-1:0];

  assign out_load = !ov_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    i_d       = i_q;
    a_d       = a_q;
    j_d       = j_q;
    start_d   = start_q;
    rc_d      = rc_q;
    oc_d      = oc_q;
    n_d       = n_q;
    fp_d      = fp_q;
    fin_d     = fin_q;
    bank_d    = bank_q;
    run_pos_d = run_pos_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    job_pop_o = 1'b0;
    rel_o     = '0;
    elem_ra   = {bank_q, i_q};
    rra       = '0;
    rwe       = 1'b0;
    rwa       = '0;
    rwd       = '0;
    emit      = 1'b0;
    emit_pos  = POS_W'(1);
    unique case (state_q)
      S_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          bank_d    = job_i.bank;
          n_d       = job_i.n;
          start_d   = J_W'(target_i) - J_W'(job_i.diff) + J_W'(ZERO);
          step_d    = '0;
          j_d       = J_W'(ZERO);
          rc_d      = '0;
          oc_d      = '0;
          fin_d     = 1'b0;
          state_d   = S_INIT;
        end
      end
      S_INIT: begin
        rwe    = 1'b1;
        rwa    = {IDX_W'(1), step_q[WA_W-1:0]};
        if (start_in && start_q[SP_W-1:WORD_LW] == step_q[WA_W-1:0]) begin
          rwd = WORD_W'(1) << start_q[WORD_LW-1:0];
        end
        step_d = step_q + ST_W'(1);
        if (step_q == ST_W'(NWORDS - 1)) begin
          if (n_q > CNT_W'(2)) begin
            i_d     = IDX_W'(2);
            state_d = S_LDA;
          end else begin
            state_d = S_I1;
          end
        end
      end
      S_LDA: state_d = S_LDA2;
      S_LDA2: begin
        a_d     = elem_rd_q;
        step_d  = '0;
        cur_d   = '0;
        prv_d   = '0;
        state_d = S_PASS;
      end
      S_PASS: begin
        rra = {i_prev, step_q[WA_W-1:0]};
        if (step_q != ST_W'(0)) begin
          prv_d = cur_q;
          cur_d = incoming;
        end
        if (step_q >= ST_W'(2)) begin
          rwe = 1'b1;
          rwa = {i_q, wstep[WA_W-1:0]};
          rwd = plus_w | minus_w;
        end
        step_d = step_q + ST_W'(1);
        if (step_q == ST_W'(NWORDS + 1)) begin
          if (CNT_W'(i_q) == n_q - CNT_W'(1)) begin
            state_d = S_TBE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_LDA;
          end
        end
      end
      S_TBE: state_d = S_TBA;
      S_TBA: begin
        a_d     = elem_rd_q;
        state_d = S_TBP;
      end
      S_TBP: begin
        rra     = {i_prev, jp[SP_W-1:WORD_LW]};
        state_d = S_TBM;
      end
      S_TBM: begin
        fp_d    = jp_in && rdata_q[jp[WORD_LW-1:0]];
        rra     = {i_prev, jm[SP_W-1:WORD_LW]};
        state_d = S_TBD;
      end
      S_TBD: begin
        if (j_in && fp_q && (!fm || a_q > 0)) begin
          rc_d    = rc_q + CNT_W'(1);
          j_d     = jp;
          i_d     = i_prev;
          state_d = (i_q > IDX_W'(2)) ? S_TBE : S_I1;
        end else begin
          j_d       = jm;
          run_pos_d = POS_W'(i_q) + POS_W'(1);
          fin_d     = 1'b0;
          state_d   = S_RUN;
        end
      end
      S_I1: begin
        run_pos_d = POS_W'(2);
        fin_d     = 1'b1;
        state_d   = S_RUN;
      end
      S_RUN: begin
        if (rc_q == '0) begin
          if (fin_q) begin
            state_d = S_FILL;
          end else begin
            i_d     = i_prev;
            state_d = (i_q > IDX_W'(2)) ? S_TBE : S_I1;
          end
        end else begin
          emit     = out_load;
          emit_pos = run_pos_q;
          if (out_load) rc_d = rc_q - CNT_W'(1);
        end
      end
      S_FILL: begin
        if (oc_q == n_q - CNT_W'(1)) begin
          rel_o.valid = 1'b1;
          rel_o.bank  = bank_q;
          state_d     = S_IDLE;
        end else begin
          emit = out_load;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit) oc_d = oc_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      i_q     <= '0;
      rc_q    <= '0;
      oc_q    <= '0;
      n_q     <= '0;
      fin_q   <= 1'b0;
      bank_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      i_q     <= i_d;
      rc_q    <= rc_d;
      oc_q    <= oc_d;
      n_q     <= n_d;
      fin_q   <= fin_d;
      bank_q  <= bank_d;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    j_q       <= j_d;
    start_q   <= start_d;
    fp_q      <= fp_d;
    run_pos_q <= run_pos_d;
    cur_q     <= cur_d;
    prv_q     <= prv_d;
    if (emit) begin
      opos_q  <= emit_pos;
      olast_q <= (oc_q == n_q - CNT_W'(2));
    end
  end

  assign out_valid_o = ov_q;
  assign position_o  = opos_q;
  assign last_res_o  = olast_q;

endmodule

[rtl/sass_check.sv]
`include "sign_assignment_sum_solver_unit_assert.svh"

module sass_check (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] position_o,
  input logic       last_res_o
);

  `SASS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(position_o) && $stable(last_res_o), "result beat changed while stalled")
  `SASS_ASSERT_NOW(a_pos_range, out_valid_o, position_o != 7'd0 && position_o <= 7'd64, "position out of range")
  `SASS_ASSERT_NOW(a_last_one, out_valid_o && last_res_o, position_o == 7'd1, "final beat not at position one")
  `SASS_ASSERT_NEXT(a_pos_order, out_valid_o && out_ready_i && !last_res_o, !out_valid_o || position_o <= $past(position_o), "positions rose within an answer")

endmodule

bind sign_assignment_sum_solver_unit sass_check u_check (.*);

[sim/sign_assignment_sum_solver_unit_checker.sv]
module sign_assignment_sum_solver_unit_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [sass_pkg::VAL_W-1:0] value_i,
  input  logic                              last_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic signed [sass_pkg::TGT_W-1:0] cfg_target_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [sass_pkg::POS_W-1:0]        position_i,
  input  logic                              last_res_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = sass_pkg::MAX_ITEMS_DEF;
  localparam int SPAN = sass_pkg::SUM_SPAN_DEF;
  localparam int MID  = SPAN / 2;

  typedef enum logic [1:0] {MARK_NONE = 2'd0, MARK_PLUS = 2'd1, MARK_MINUS = 2'd2} mark_e;

  typedef struct {
    logic [sass_pkg::POS_W-1:0] pos;
    logic                       fin;
  } step_t;

  step_t                      steps_q[$];
  logic signed [sass_pkg::TGT_W-1:0] tgt;
  int                         elems[NMAX];
  int                         seq_len;
  mark_e                      reach[NMAX][SPAN];
  bit                         plus_sign[NMAX];

  function automatic bit on_row(int j);
    return j >= 0 && j < SPAN;
  endfunction

  function automatic void push_step(int pos);
    step_t s;
    s.pos = pos[sass_pkg::POS_W-1:0];
    s.fin = 1'b0;
    steps_q.push_back(s);
  endfunction

  // contraction order for one closed sequence
  function automatic void solve_sequence(int n);
    int start, a, j, run, left, base;
    bit fp, fm;
    base = steps_q.size();
    if (n <= 1) return;
    if (n == 2) begin
      push_step(1);
    end else begin
      start = int'(tgt) - (elems[0] - elems[1]) + MID;
      for (int p = 0; p < SPAN; p++) reach[1][p] = MARK_NONE;
      if (on_row(start)) reach[1][start] = MARK_PLUS;
      for (int i = 2; i < n; i++) begin
        a = elems[i];
        for (int p = 0; p < SPAN; p++) begin
          fp = on_row(p + a) && reach[i-1][p+a] != MARK_NONE;
          fm = on_row(p - a) && reach[i-1][p-a] != MARK_NONE;
          if (fp && fm) reach[i][p] = (a > 0) ? MARK_PLUS : MARK_MINUS;
          else if (fp) reach[i][p] = MARK_PLUS;
          else if (fm) reach[i][p] = MARK_MINUS;
          else reach[i][p] = MARK_NONE;
        end
      end
      j = MID;
      for (int i = n - 1; i >= 2; i--) begin
        if (on_row(j) && reach[i][j] == MARK_PLUS) begin
          j += elems[i];
          plus_sign[i] = 1'b1;
        end else begin
          j -= elems[i];
          plus_sign[i] = 1'b0;
        end
      end
      plus_sign[1] = 1'b0;
      run = 0;
      left = n;
      for (int i = n - 1; i >= 1; i--) begin
        if (plus_sign[i]) begin
          run++;
        end else begin
          for (int r = 0; r < run; r++) push_step(i + 1);
          left -= run;
          run = 0;
        end
      end
      for (int i = 1; i < left; i++) push_step(1);
    end
    if (steps_q.size() > base) steps_q[steps_q.size()-1].fin = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    step_t want;
    if (!rst_ni) begin
      steps_q.delete();
      tgt = '0;
      seq_len = 0;
      fail_count_o <= 0;
      checked_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tgt = cfg_target_i;
      if (in_valid_i && in_ready_i) begin
        if (seq_len < NMAX) begin
          elems[seq_len] = int'(value_i);
          seq_len++;
        end
        if (last_i) begin
          solve_sequence(seq_len);
          seq_len = 0;
        end
      end
      if (out_valid_i && out_ready_i) begin
        checked_o <= checked_o + 1;
        if (steps_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result beat: position %0d last %0b", position_i, last_res_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = steps_q.pop_front();
          if (want.pos !== position_i || want.fin !== last_res_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected position %0d last %0b, got position %0d last %0b",
                       want.pos, want.fin, position_i, last_res_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= steps_q.size();
    end
  end

endmodule

[sim/sign_assignment_sum_solver_unit_tb.sv]
module sign_assignment_sum_solver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [sass_pkg::VAL_W-1:0] value_i = '0;
  logic last_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic signed [sass_pkg::TGT_W-1:0] cfg_target_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [sass_pkg::POS_W-1:0] position_o;
  logic last_res_o;

  int fail_count, pending, checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int seq_total = 0;
  int item_total = 0;
  int cur_target = 0;
  int vals[70];

  always #4 clk_i = ~clk_i;

  sign_assignment_sum_solver_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_i, .last_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_target_i,
    .out_valid_o, .out_ready_i, .position_o, .last_res_o
  );

  sign_assignment_sum_solver_unit_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .value_i, .last_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_target_i,
    .out_valid_i(out_valid_o), .out_ready_i, .position_i(position_o),
    .last_res_i(last_res_o), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  // receiver ready, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 3000;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(int v, bit fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= v[sass_pkg::VAL_W-1:0];
    last_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    item_total++;
    @(negedge clk_i);
  endtask

  task automatic send_seq(int n);
    for (int i = 0; i < n; i++) send_beat(vals[i], i == n - 1);
    seq_total++;
  endtask

  // random content; mostly built so the current target is reachable
  task automatic rand_seq(int n, int mag);
    int s, d;
    for (int i = 0; i < n; i++) vals[i] = $urandom_range(2 * mag) - mag;
    if (n >= 3 && $urandom_range(9) < 8) begin
      s = vals[0] - vals[1];
      for (int i = 2; i < n - 1; i++) s += $urandom_range(1) ? vals[i] : -vals[i];
      d = cur_target - s;
      if (d >= -127 && d <= 127) vals[n-1] = d;
    end
    send_seq(n);
  endtask

  task automatic set_target(int t);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_target_i <= t[sass_pkg::TGT_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_target = t;
  endtask

  task automatic rand_phase(int t, int ipct, int spct, int nseq);
    int n;
    set_target(t);
    idle_pct = ipct;
    stall_pct = spct;
    for (int k = 0; k < nseq; k++) begin
      n = $urandom_range(6, 1);
      rand_seq(n, ($urandom_range(3) == 0) ? 127 : 20);
    end
    if ($urandom_range(1)) begin
      vals[0] = -128;
      vals[1] = 127;
      send_seq(2);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single, pair, extremes, zeros, ties
    vals[0] = 5; send_seq(1);
    vals[0] = 127; vals[1] = -128; send_seq(2);
    vals[0] = -128; vals[1] = 127; vals[2] = 0; vals[3] = 255; send_seq(4);
    vals[0] = 0; vals[1] = 0; vals[2] = 0; vals[3] = 0; send_seq(4);
    vals[0] = 3; vals[1] = 1; vals[2] = 1; vals[3] = -1; vals[4] = 1; send_seq(5);
    vals[0] = 1; vals[1] = 2; vals[2] = 1; vals[3] = 1; vals[4] = 1; send_seq(5);
    set_target(16383);
    vals[0] = 1; vals[1] = 2; vals[2] = 4; send_seq(3);
    vals[0] = 127; vals[1] = -128; vals[2] = 85; vals[3] = -86; send_seq(4);
    set_target(-16384);
    vals[0] = -128; vals[1] = 127; vals[2] = 127; send_seq(3);
    set_target(8192);
    vals[0] = 10; vals[1] = 20; vals[2] = 30; send_seq(3);
    set_target(-8192);
    // too many elements, extra ones dropped
    for (int i = 0; i < 65; i++) vals[i] = -127 + 2 * (i % 128);
    send_seq(65);

    rand_phase($urandom_range(200) - 100, 0, 0, 2);
    rand_phase($urandom_range(600) - 300, 72, 0, 2);
    rand_phase($urandom_range(600) - 300, 0, 72, 2);
    rand_phase($urandom_range(600) - 300, 24, 24, 2);
    // long receiver hold-off while short sequences keep coming
    set_target(0);
    idle_pct = 0;
    stall_pct = 0;
    hold_trig = hold_trig + 1;
    for (int k = 0; k < 4; k++) rand_seq($urandom_range(4, 2), 30);
    rand_phase(8192, 24, 24, 2);
    rand_phase($urandom_range(400) - 200, 0, 0, 2);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
    $display("run covered %0d sequences, %0d input beats, %0d result beats checked",
             seq_total, item_total, checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/sass_pkg.sv
rtl/sass_fifo.sv
rtl/sass_front.sv
rtl/sass_back.sv
rtl/sign_assignment_sum_solver_unit.sv
rtl/sass_check.sv
sim/sign_assignment_sum_solver_unit_checker.sv
sim/sign_assignment_sum_solver_unit_tb.sv
